@@ sv/cops_pkg.sv @@
// Shared types, widths and register codes of the clock offset PI servo.
`default_nettype none

package cops_pkg;

  localparam int unsigned TIME_W     = 64;
  localparam int unsigned GAIN_W     = 32;
  localparam int unsigned LIMIT_W    = 63;
  localparam int unsigned REG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;

  localparam int unsigned GAIN_FRAC_BITS_DEF = 16;

  // exact gain * time product and the sum of two of them
  localparam int unsigned PROD_W = TIME_W + GAIN_W;
  localparam int unsigned SUM_W  = PROD_W + 1;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_GAIN_P      = 2'd0,
    REG_GAIN_I      = 2'd1,
    REG_CORR_LIMIT  = 2'd2,
    REG_STEP_THRESH = 2'd3
  } cops_reg_e;

  typedef enum logic {
    KIND_STEP = 1'b0,
    KIND_SLEW = 1'b1
  } cops_kind_e;

  typedef struct packed {
    logic signed [TIME_W-1:0] master_send_time;
    logic signed [TIME_W-1:0] local_receive_time;
    logic signed [TIME_W-1:0] local_send_time;
    logic signed [TIME_W-1:0] master_receive_time;
  } cops_in_t;

  typedef struct packed {
    logic                     correction_kind;
    logic signed [TIME_W-1:0] correction_amount;
    logic signed [TIME_W-1:0] measured_offset;
  } cops_out_t;

  typedef struct packed {
    logic [REG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } cops_cfg_t;

endpackage

`default_nettype wire

@@ sv/cops_stream_if.sv @@
// Valid/ready stream channel with a typed payload.
`default_nettype none

interface cops_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ sv/clock_offset_pi_servo_unit.sv @@
// Clock offset PI servo: sync round timestamps in, step or slew correction out.
//
// in_i carries one sync round per beat (t1..t4, signed ns). out_o returns exactly
// one beat per round: a step by the measured offset (first round only, when the
// offset magnitude exceeds the step threshold) or a slew correction from the PI
// loop, clamped to the correction limit. cfg_i writes gain_p, gain_i,
// correction_limit and step_threshold; it is always ready, and the user must write
// it only while no round is in flight, as the block does not enforce this.
// A round passes through the ten register stages on its way to out_o
// (input, timestamp differences, round trip, offset, accumulator, partial
// products of the 32 x 64 multiplies, full products, product sum, truncating
// shift, clamp and result). One round per cycle is taken when the output is not
// stalled; the integral accumulator is a single register fed back on itself,
// so back-to-back rounds need no bubble.
// Reset clears the configuration registers, the accumulator and the first-round
// flag and empties the pipeline. When out_o stalls, each stage holds only while the stage
// after it is full, so bubbles close up and in_i keeps taking beats until the
// pipeline is full.
`default_nettype none

module clock_offset_pi_servo_unit
  import cops_pkg::*;
#(
  parameter int unsigned GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  cops_stream_if.sink   in_i,
  cops_stream_if.source out_o,
  cops_stream_if.sink   cfg_i
);

  localparam int unsigned NSTG = 10;
  localparam logic [SUM_W-1:0] RND_BIAS =
    SUM_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);
  localparam logic signed [TIME_W-1:0] ESUM_MAX = {1'b0, {(TIME_W-1){1'b1}}};
  localparam logic signed [TIME_W-1:0] ESUM_MIN = {1'b1, {(TIME_W-1){1'b0}}};

  // configuration
  logic signed [GAIN_W-1:0]  gain_p_q, gain_i_q;
  logic        [LIMIT_W-1:0] limit_q, thresh_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q <= '0;
      gain_i_q <= '0;
      limit_q  <= '0;
      thresh_q <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cops_reg_e'(cfg_i.data.index))
        REG_GAIN_P:      gain_p_q <= cfg_i.data.value[GAIN_W-1:0];
        REG_GAIN_I:      gain_i_q <= cfg_i.data.value[GAIN_W-1:0];
        REG_CORR_LIMIT:  limit_q  <= cfg_i.data.value[LIMIT_W-1:0];
        REG_STEP_THRESH: thresh_q <= cfg_i.data.value[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control: a stage loads when it is empty or its successor loads
  logic [NSTG-1:0] vld_q;
  logic [NSTG:0]   rdy;

  always_comb begin
    rdy[NSTG] = out_o.ready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign in_i.ready  = rdy[0];
  assign out_o.valid = vld_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= in_i.valid;
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // stage 0: timestamps
  logic signed [TIME_W-1:0] t1_q, t2_q, t3_q, t4_q;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      t1_q <= in_i.data.master_send_time;
      t2_q <= in_i.data.local_receive_time;
      t3_q <= in_i.data.local_send_time;
      t4_q <= in_i.data.master_receive_time;
    end
  end

  // stage 1: differences
  logic signed [TIME_W-1:0] d41_q, d32_q, d21a_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      d41_q  <= t4_q - t1_q;
      d32_q  <= t3_q - t2_q;
      d21a_q <= t2_q - t1_q;
    end
  end

  // stage 2: round trip
  logic signed [TIME_W-1:0] rtt_q, d21b_q;

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      rtt_q  <= d41_q - d32_q;
      d21b_q <= d21a_q;
    end
  end

  // stage 3: offset; halve toward zero by biasing negative values by one
  logic signed [TIME_W-1:0] off_q [3:8];
  logic                     step_q [4:8];
  logic signed [TIME_W-1:0] owd;

  always_comb begin
    owd = (rtt_q + $signed({{(TIME_W-1){1'b0}}, rtt_q[TIME_W-1]})) >>> 1;
  end

  // stage 4: step decision and saturating integral accumulator
  logic                     done_q;
  logic signed [TIME_W-1:0] esum_q, esum_d, esum4_q;
  logic        [TIME_W-1:0] off_mag;
  logic        [TIME_W:0]   sum_ext;
  logic                     step_now;

  always_comb begin
    off_mag  = off_q[3][TIME_W-1] ? (TIME_W'(0) - off_q[3]) : off_q[3];
    step_now = !done_q && (off_mag > {1'b0, thresh_q});
    sum_ext  = {esum_q[TIME_W-1], esum_q} + {off_q[3][TIME_W-1], off_q[3]};
    if (step_now) begin
      esum_d = esum_q;
    end else if (sum_ext[TIME_W] != sum_ext[TIME_W-1]) begin
      esum_d = sum_ext[TIME_W] ? ESUM_MIN : ESUM_MAX;
    end else begin
      esum_d = sum_ext[TIME_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      esum_q <= '0;
    end else if (rdy[4] && vld_q[3]) begin
      done_q <= 1'b1;
      esum_q <= esum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      esum4_q <= esum_d;
    end
  end

  // stage 5: partial products, gain times low (unsigned) and high (signed) halves
  logic signed [GAIN_W+GAIN_W:0] ppl_q, pil_q;
  logic signed [GAIN_W+GAIN_W-1:0] pph_q, pih_q;

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      ppl_q <= gain_p_q * $signed({1'b0, off_q[4][GAIN_W-1:0]});
      pph_q <= gain_p_q * $signed(off_q[4][TIME_W-1:GAIN_W]);
      pil_q <= gain_i_q * $signed({1'b0, esum4_q[GAIN_W-1:0]});
      pih_q <= gain_i_q * $signed(esum4_q[TIME_W-1:GAIN_W]);
    end
  end

  // stage 6: full products
  logic signed [PROD_W-1:0] prod_p_q, prod_i_q;

  always_ff @(posedge clk_i) begin
    if (rdy[6]) begin
      prod_p_q <= $signed({pph_q, {GAIN_W{1'b0}}}) + PROD_W'(ppl_q);
      prod_i_q <= $signed({pih_q, {GAIN_W{1'b0}}}) + PROD_W'(pil_q);
    end
  end

  // stage 7: P plus I
  logic signed [SUM_W-1:0] sum_q;

  always_ff @(posedge clk_i) begin
    if (rdy[7]) sum_q <= SUM_W'(prod_p_q) + SUM_W'(prod_i_q);
  end

  // stage 8: drop fraction bits, truncating toward zero
  logic signed [SUM_W-1:0] sum_rnd, quot_q;

  always_comb begin
    sum_rnd = sum_q + $signed(sum_q[SUM_W-1] ? RND_BIAS : {SUM_W{1'b0}});
  end

  always_ff @(posedge clk_i) begin
    if (rdy[8]) quot_q <= sum_rnd >>> GAIN_FRAC_BITS;
  end

  // carry the offset and the step flag alongside the arithmetic
  always_ff @(posedge clk_i) begin
    if (rdy[3]) off_q[3] <= owd - d21b_q;
    if (rdy[4]) begin
      off_q[4]  <= off_q[3];
      step_q[4] <= step_now;
    end
    for (int k = 5; k <= 8; k++) begin
      if (rdy[k]) begin
        off_q[k]  <= off_q[k-1];
        step_q[k] <= step_q[k-1];
      end
    end
  end

  // stage 9: clamp and result register
  logic signed [SUM_W-1:0]  lim_s, clamped;
  logic signed [TIME_W-1:0] amount;
  cops_out_t                out_q;

  always_comb begin
    lim_s = $signed(SUM_W'(limit_q));
    if (quot_q > lim_s) begin
      clamped = lim_s;
    end else if (quot_q < -lim_s) begin
      clamped = -lim_s;
    end else begin
      clamped = quot_q;
    end
    amount = step_q[8] ? off_q[8] : clamped[TIME_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (rdy[9]) begin
      out_q.correction_kind   <= step_q[8] ? KIND_STEP : KIND_SLEW;
      out_q.correction_amount <= amount;
      out_q.measured_offset   <= off_q[8];
    end
  end

  assign out_o.data = out_q;

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// Testbench of the clock offset PI servo: random sync rounds against an in-bench servo predictor.

module tb;
  import cops_pkg::*;

  localparam int unsigned FRAC           = GAIN_FRAC_BITS_DEF;
  localparam logic [63:0] T_MIN          = 64'h8000_0000_0000_0000;
  localparam logic [63:0] T_MAX          = 64'h7fff_ffff_ffff_ffff;
  localparam logic [62:0] LIM_MAX        = {63{1'b1}};
  localparam int unsigned PHASE_ROUNDS   = 320;
  localparam int unsigned HOLD_CYCLES    = 160;
  localparam int unsigned TIMEOUT_CYCLES = 400000;

  // Servo predictor and the queue of corrections it expects.
  class servo_scoreboard;
    logic signed [31:0] gain_p;
    logic signed [31:0] gain_i;
    logic [62:0]        corr_limit;
    logic [62:0]        step_thresh;
    bit                 synced;
    logic [63:0]        err_sum;
    cops_out_t          pending_corrections[$];
    int unsigned        fails;

    function new();
      gain_p      = '0;
      gain_i      = '0;
      corr_limit  = '0;
      step_thresh = '0;
      synced      = 1'b0;
      err_sum     = '0;
      fails       = 0;
    endfunction

    function void write_reg(cops_reg_e idx, logic [63:0] value);
      case (idx)
        REG_GAIN_P:      gain_p      = value[31:0];
        REG_GAIN_I:      gain_i      = value[31:0];
        REG_CORR_LIMIT:  corr_limit  = value[62:0];
        REG_STEP_THRESH: step_thresh = value[62:0];
        default: ;
      endcase
    endfunction

    function void note_round(cops_in_t r);
      logic [63:0]         rtt, rtt_mag, owd, ofs, ofs_mag, amount_mag;
      logic signed [64:0]  sum65;
      logic signed [127:0] gp_w, gi_w, ofs_w, err_w, total;
      logic [127:0]        total_mag;
      bit                  neg;
      cops_out_t           e;
      rtt     = (r.master_receive_time - r.master_send_time)
              - (r.local_send_time - r.local_receive_time);
      // halve toward zero
      rtt_mag = rtt[63] ? 64'd0 - rtt : rtt;
      owd     = rtt[63] ? 64'd0 - (rtt_mag >> 1) : rtt_mag >> 1;
      ofs     = owd - (r.local_receive_time - r.master_send_time);
      e.measured_offset = ofs;
      if (!synced) begin
        synced  = 1'b1;
        ofs_mag = ofs[63] ? 64'd0 - ofs : ofs;
        if (ofs_mag > {1'b0, step_thresh}) begin
          e.correction_kind   = KIND_STEP;
          e.correction_amount = ofs;
          pending_corrections.push_back(e);
          return;
        end
      end
      sum65 = $signed({err_sum[63], err_sum}) + $signed({ofs[63], ofs});
      if (sum65[64] != sum65[63]) begin
        err_sum = sum65[64] ? T_MIN : T_MAX;
      end else begin
        err_sum = sum65[63:0];
      end
      gp_w  = gain_p;
      gi_w  = gain_i;
      ofs_w = $signed(ofs);
      err_w = $signed(err_sum);
      total = gp_w * ofs_w + gi_w * err_w;
      neg   = total[127];
      total_mag = neg ? 128'd0 - total : total;
      total_mag = total_mag >> FRAC;
      amount_mag = (total_mag > {65'd0, corr_limit}) ? {1'b0, corr_limit} : total_mag[63:0];
      e.correction_kind   = KIND_SLEW;
      e.correction_amount = neg ? 64'd0 - amount_mag : amount_mag;
      pending_corrections.push_back(e);
    endfunction

    function void report(string field, logic [63:0] exp_v, logic [63:0] act_v);
      fails++;
      $error("%s mismatch: expected %0d, actual %0d", field, $signed(exp_v), $signed(act_v));
    endfunction

    function void check_correction(cops_out_t got);
      cops_out_t e;
      if (pending_corrections.size() == 0) begin
        fails++;
        $error("correction beat with no round pending: amount %0d offset %0d",
               got.correction_amount, got.measured_offset);
        return;
      end
      e = pending_corrections.pop_front();
      if (got.correction_kind !== e.correction_kind) begin
        report("correction_kind", 64'(e.correction_kind), 64'(got.correction_kind));
      end
      if (got.correction_amount !== e.correction_amount) begin
        report("correction_amount", e.correction_amount, got.correction_amount);
      end
      if (got.measured_offset !== e.measured_offset) begin
        report("measured_offset", e.measured_offset, got.measured_offset);
      end
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  cops_stream_if #(.payload_t(cops_in_t))  round_ch ();
  cops_stream_if #(.payload_t(cops_out_t)) corr_ch ();
  cops_stream_if #(.payload_t(cops_cfg_t)) cfg_ch ();

  servo_scoreboard sb = new();

  int unsigned burst_left;
  bit          no_gaps;
  bit          hold_req;

  clock_offset_pi_servo_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (round_ch),
    .out_o  (corr_ch),
    .cfg_i  (cfg_ch)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && round_ch.valid && round_ch.ready) begin
      sb.note_round(round_ch.data);
    end
    if (rst_ni && corr_ch.valid && corr_ch.ready) begin
      sb.check_correction(corr_ch.data);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] extreme_val();
    case ($urandom_range(0, 5))
      0: return T_MIN;
      1: return T_MAX;
      2: return 64'd0;
      3: return {64{1'b1}};
      4: return 64'd1;
      default: return rand64();
    endcase
  endfunction

  function automatic cops_in_t mk_round(logic [63:0] t1, logic [63:0] t2,
                                        logic [63:0] t3, logic [63:0] t4);
    cops_in_t r;
    r.master_send_time    = t1;
    r.local_receive_time  = t2;
    r.local_send_time     = t3;
    r.master_receive_time = t4;
    return r;
  endfunction

  // zero round trip, so the offset comes out exactly as given
  function automatic cops_in_t offset_round(logic [63:0] ofs);
    return mk_round(64'd0, 64'd0 - ofs, 64'd0 - ofs, 64'd0);
  endfunction

  function automatic cops_in_t random_round();
    int unsigned sel;
    logic [63:0] t1, t2, t3, dly, ofs, turn;
    sel = $urandom_range(0, 19);
    if (sel < 2) begin
      return mk_round(rand64(), rand64(), rand64(), rand64());
    end else if (sel == 2) begin
      return mk_round(extreme_val(), extreme_val(), extreme_val(), extreme_val());
    end
    // plausible exchange: symmetric path delay plus an offset, odd trip now and then
    dly  = 64'($urandom_range(0, 200000));
    turn = 64'($urandom_range(0, 50000));
    ofs  = $signed(rand64()) >>> $urandom_range(20, 62);
    t1   = rand64();
    t2   = t1 + dly - ofs;
    t3   = t2 + turn;
    return mk_round(t1, t2, t3, t3 + dly + ofs + 64'($urandom_range(0, 1)));
  endfunction

  function automatic logic signed [31:0] rand_gain();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom;
      default: return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
    endcase
  endfunction

  function automatic logic [62:0] rand_limit();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return LIM_MAX;
      2: return 63'($urandom_range(0, 1000000));
      default: return 63'(rand64() >> $urandom_range(1, 40));
    endcase
  endfunction

  task automatic put_round(cops_in_t r);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        @(negedge clk_i);
        round_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    round_ch.valid <= 1'b1;
    round_ch.data  <= r;
    do @(posedge clk_i); while (!round_ch.ready);
  endtask

  // drop valid and wait for every pending correction
  task automatic drain();
    @(negedge clk_i);
    round_ch.valid <= 1'b0;
    burst_left = 0;
    while (sb.pending_corrections.size() != 0) @(posedge clk_i);
    repeat (14) @(posedge clk_i);
  endtask

  task automatic write_reg(cops_reg_e idx, logic [63:0] value);
    @(negedge clk_i);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.data.index <= idx;
    cfg_ch.data.value <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    sb.write_reg(idx, value);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_config(logic signed [31:0] gp, logic signed [31:0] gi,
                            logic [62:0] lim, logic [62:0] thr);
    write_reg(REG_GAIN_P, {{32{gp[31]}}, gp});
    write_reg(REG_GAIN_I, {{32{gi[31]}}, gi});
    write_reg(REG_CORR_LIMIT, {1'b0, lim});
    write_reg(REG_STEP_THRESH, {1'b0, thr});
  endtask

  // receiver: rotate through stall patterns, with a long hold-off on request
  initial begin
    int unsigned cyc;
    cyc = 0;
    corr_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      cyc++;
      if (hold_req) begin
        hold_req = 1'b0;
        corr_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        case ((cyc / 200) % 4)
          0: corr_ch.ready <= 1'b1;
          1: corr_ch.ready <= 1'($urandom_range(0, 1));
          2: corr_ch.ready <= ($urandom_range(0, 3) == 0);
          default: corr_ch.ready <= ((cyc % 8) < 5);
        endcase
      end
    end
  end

  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk_i);
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic [62:0]        thr;
    logic signed [31:0] gp, gi;
    logic [62:0]        lim;
    bit                 first_at_edge;
    round_ch.valid = 1'b0;
    round_ch.data  = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.data    = '0;
    burst_left     = 0;
    no_gaps        = 1'b0;
    hold_req       = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // first round: either sits exactly on the threshold or is the most negative offset
    first_at_edge = 1'($urandom_range(0, 1));
    thr = first_at_edge ? 63'(rand64() >> 2) : LIM_MAX;
    set_config(32'sd65536, 32'sd4096, LIM_MAX, thr);
    put_round(first_at_edge ? offset_round({1'b0, thr}) : offset_round(T_MIN));
    put_round(mk_round(64'd0, 64'd0, 64'd0, 64'd0));
    put_round(mk_round(T_MAX, T_MAX, T_MAX, T_MAX));
    put_round(mk_round(T_MIN, T_MIN, T_MIN, T_MIN));
    put_round(mk_round(T_MIN, T_MAX, T_MIN, T_MAX));
    put_round(mk_round(T_MAX, T_MIN, T_MAX, T_MIN));
    put_round(mk_round({64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}}));
    put_round(mk_round(64'd0, 64'd0, 64'd3, 64'd0));
    put_round(mk_round(64'd0, 64'd0, 64'd0, 64'd5));
    put_round(mk_round(64'd0, 64'd0, 64'd0, T_MIN));
    // saturate the integral both ways
    repeat (4) put_round(offset_round(T_MAX));
    repeat (5) put_round(offset_round(T_MIN));
    put_round(offset_round(64'd1));
    put_round(offset_round({64{1'b1}}));
    drain();
    set_config(32'sh8000_0000, 32'sh7fff_ffff, '0, '0);
    repeat (3) put_round(offset_round(rand64()));
    drain();
    set_config(32'sh7fff_ffff, 32'sh8000_0000, 63'd1000, LIM_MAX);
    repeat (3) put_round(offset_round(rand64() >>> 8));

    for (int p = 0; p < 6; p++) begin
      drain();
      gp  = rand_gain();
      gi  = rand_gain();
      lim = rand_limit();
      thr = ($urandom_range(0, 1) == 0) ? '0 : rand_limit();
      case (p)
        0: begin
          gp  = 32'sd65536;
          gi  = 32'sd1024;
          lim = LIM_MAX;
        end
        1: begin
          gp  = 32'sh8000_0000;
          gi  = 32'sh7fff_ffff;
          lim = LIM_MAX;
        end
        2: lim = '0;
        3: begin
          gp = 32'sh7fff_ffff;
          gi = 32'sh8000_0000;
        end
        default: ;
      endcase
      set_config(gp, gi, lim, thr);
      no_gaps = (p == 2);
      // pull the integral back near zero so small offsets matter again
      put_round(offset_round((sb.err_sum == T_MIN) ? T_MAX : 64'd0 - sb.err_sum));
      for (int k = 0; k < PHASE_ROUNDS; k++) begin
        put_round(random_round());
        if ((p == 2 || p == 4) && k == 100) begin
          hold_req = 1'b1;
        end
      end
    end

    drain();
    if (sb.fails == 0 && sb.pending_corrections.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
